// ----- sv/sync_length_frame_receiver_top_macros.svh -----
// assertion macros for the sync/length frame receiver
// included by the top level; no other dependencies
`ifndef SYNC_LENGTH_FRAME_RECEIVER_TOP_MACROS_SVH
`define SYNC_LENGTH_FRAME_RECEIVER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, checked on clk, quiet during reset
`define SLFR_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("slfr assertion failed");
// next-cycle implication, checked on clk, quiet during reset
`define SLFR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("slfr assertion failed");
`else
`define SLFR_ASSERT_IMPL(lbl, ante, cons)
`define SLFR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- sv/slfr_pkg.sv -----
// shared types and constants of the sync/length frame receiver
// used by all modules of the block; no dependencies
package slfr_pkg;

	localparam logic [7:0] SYNC_BYTE = 8'h55;

	// parser phases
	localparam int PHASE_W = 3;
	localparam logic [PHASE_W-1:0] PH_SYNC = 3'd0;
	localparam logic [PHASE_W-1:0] PH_CMD  = 3'd1;
	localparam logic [PHASE_W-1:0] PH_ID   = 3'd2;
	localparam logic [PHASE_W-1:0] PH_LEN  = 3'd3;
	localparam logic [PHASE_W-1:0] PH_DATA = 3'd4;
	localparam logic [PHASE_W-1:0] PH_CHK1 = 3'd5;
	localparam logic [PHASE_W-1:0] PH_CHK2 = 3'd6;

	// result kinds
	localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
	localparam logic [1:0] KIND_ACCEPTED = 2'd1;
	localparam logic [1:0] KIND_REJECTED = 2'd2;
	localparam logic [1:0] KIND_TIMEOUT  = 2'd3;

	// register indexes
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_OWN_ID     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BCAST_ADDR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_ANY = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 2'd3;

	localparam int IN_TDATA_W  = 8;
	localparam int IN_TUSER_W  = 1;
	localparam int OUT_TDATA_W = 56;
	localparam int OUT_TUSER_W = 2;

	typedef struct packed {
		logic [7:0]  own_id;
		logic [7:0]  broadcast_address;
		logic        accept_any_id;
		logic [15:0] timeout_ticks;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  payload_byte;
		logic [7:0]  payload_index;
		logic [7:0]  frame_command;
		logic [7:0]  frame_id;
		logic [7:0]  frame_length;
		logic [15:0] received_check;
		logic        last;
	} res_t;

endpackage

// ----- sv/slfr_cfg_regs.sv -----
// configuration registers of the frame receiver
// depends on slfr_pkg
module slfr_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [slfr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [slfr_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output slfr_pkg::cfg_t                 cfg
);
	import slfr_pkg::*;

	cfg_t cfg_q;

	// register writes, one index per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.own_id            <= 8'd0;
			cfg_q.broadcast_address <= 8'd255;
			cfg_q.accept_any_id     <= 1'b0;
			cfg_q.timeout_ticks     <= 16'd100;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_OWN_ID:     cfg_q.own_id            <= cfg_wdata[7:0];
				REG_BCAST_ADDR: cfg_q.broadcast_address <= cfg_wdata[7:0];
				REG_ACCEPT_ANY: cfg_q.accept_any_id     <= cfg_wdata[0];
				REG_TIMEOUT:    cfg_q.timeout_ticks     <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- sv/slfr_parser.sv -----
// frame parser: phase register, held header, tick aging and result forming
// depends on slfr_pkg
module slfr_parser (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	input  logic           cmd,
	input  logic [7:0]     rx_byte,
	input  slfr_pkg::cfg_t cfg,
	output logic           res_valid,
	output slfr_pkg::res_t res
);
	import slfr_pkg::*;

	logic [PHASE_W-1:0] phase_q, phase_d;
	logic [7:0]  command_q, command_d;
	logic [7:0]  id_q, id_d;
	logic [7:0]  length_q, length_d;
	logic [7:0]  count_q, count_d;
	logic [15:0] check_q, check_d;
	logic [15:0] ticks_q, ticks_d;
	logic [7:0]  count_inc;
	logic [15:0] ticks_inc;
	logic [15:0] check_full;
	logic        id_ok;

	assign count_inc  = count_q + 8'd1;
	assign ticks_inc  = (ticks_q == 16'hFFFF) ? ticks_q : ticks_q + 16'd1;
	assign check_full = {check_q[15:8], rx_byte};
	assign id_ok      = (id_q == cfg.own_id) || (id_q == cfg.broadcast_address)
		|| cfg.accept_any_id;

	// next state and result for one item
	always_comb begin
		phase_d   = phase_q;
		command_d = command_q;
		id_d      = id_q;
		length_d  = length_q;
		count_d   = count_q;
		check_d   = check_q;
		ticks_d   = ticks_q;
		res_valid = 1'b0;
		res.kind           = KIND_PAYLOAD;
		res.payload_byte   = 8'd0;
		res.payload_index  = 8'd0;
		res.frame_command  = command_q;
		res.frame_id       = id_q;
		res.frame_length   = length_q;
		res.received_check = 16'd0;
		res.last           = 1'b0;
		if (cmd) begin
			// tick: age an open frame
			if (phase_q != PH_SYNC) begin
				ticks_d = ticks_inc;
				if (ticks_inc > cfg.timeout_ticks) begin
					res_valid          = 1'b1;
					res.kind           = KIND_TIMEOUT;
					res.received_check = check_q;
					phase_d            = PH_SYNC;
				end
			end
		end else begin
			case (phase_q)
				PH_SYNC: begin
					if (rx_byte == SYNC_BYTE) begin
						command_d = 8'd0;
						id_d      = 8'd0;
						length_d  = 8'd0;
						count_d   = 8'd0;
						check_d   = 16'd0;
						ticks_d   = 16'd0;
						phase_d   = PH_CMD;
					end
				end
				PH_CMD: begin
					command_d = rx_byte;
					phase_d   = PH_ID;
				end
				PH_ID: begin
					id_d    = rx_byte;
					phase_d = PH_LEN;
				end
				PH_LEN: begin
					length_d = rx_byte;
					count_d  = 8'd0;
					phase_d  = (rx_byte == 8'd0) ? PH_CHK1 : PH_DATA;
				end
				PH_DATA: begin
					count_d           = count_inc;
					res_valid         = 1'b1;
					res.payload_byte  = rx_byte;
					res.payload_index = count_q;
					res.last          = (count_inc == length_q);
					if (count_inc == length_q) begin
						phase_d = PH_CHK1;
					end
				end
				PH_CHK1: begin
					check_d = {rx_byte, 8'd0};
					phase_d = PH_CHK2;
				end
				PH_CHK2: begin
					check_d            = check_full;
					res_valid          = 1'b1;
					res.kind           = id_ok ? KIND_ACCEPTED : KIND_REJECTED;
					res.received_check = check_full;
					phase_d            = PH_SYNC;
				end
				default: begin
					phase_d = PH_SYNC;
				end
			endcase
		end
		if (!item_valid) begin
			res_valid = 1'b0;
		end
	end

	// parser state, updated on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_SYNC;
			command_q <= 8'd0;
			id_q      <= 8'd0;
			length_q  <= 8'd0;
			count_q   <= 8'd0;
			check_q   <= 16'd0;
			ticks_q   <= 16'd0;
		end else if (item_valid) begin
			phase_q   <= phase_d;
			command_q <= command_d;
			id_q      <= id_d;
			length_q  <= length_d;
			count_q   <= count_d;
			check_q   <= check_d;
			ticks_q   <= ticks_d;
		end
	end

endmodule

// ----- sv/slfr_out_skid.sv -----
// result register with a skid slot behind it
// depends on slfr_pkg
module slfr_out_skid (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  slfr_pkg::res_t in_res,
	output logic           in_ready,
	output logic           out_valid,
	output slfr_pkg::res_t out_res,
	input  logic           out_ready
);
	import slfr_pkg::*;

	logic main_valid_q;
	logic skid_valid_q;
	res_t main_q;
	res_t skid_q;
	logic main_free;

	assign main_free = !main_valid_q || out_ready;

	// slot occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (main_free) begin
			main_valid_q <= skid_valid_q || in_valid;
			skid_valid_q <= skid_valid_q && in_valid;
		end else if (in_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (main_free) begin
			if (skid_valid_q) begin
				main_q <= skid_q;
				skid_q <= in_res;
			end else begin
				main_q <= in_res;
			end
		end else if (in_valid) begin
			skid_q <= in_res;
		end
	end

	assign in_ready  = !skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_res   = main_q;

endmodule

// ----- sv/sync_length_frame_receiver_top.sv -----
// top level of the sync/length frame receiver
// depends on slfr_pkg, slfr_cfg_regs, slfr_parser, slfr_out_skid and the macro header
//
// channel   direction  handshake          contents
// s_*       in         s_tvalid/s_tready  received byte or time tick
// m_*       out        m_tvalid/m_tready  payload byte, frame result or timeout
// cfg_*     in         cfg_we             register index and write data
//
// one item accepted per cycle while s_tready is high; its result is registered in the output register or the skid slot
// the parser forms each result combinationally from the item and its phase register
// s_tready drops only while both the output register and the skid slot hold results
// reset clears the phase, the held frame and both output slots and loads register defaults
`include "sync_length_frame_receiver_top_macros.svh"
module sync_length_frame_receiver_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// rx_byte[7:0]
	input  logic [slfr_pkg::IN_TDATA_W-1:0]  s_tdata,
	// cmd[0]
	input  logic [slfr_pkg::IN_TUSER_W-1:0]  s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// payload_byte[7:0], payload_index[15:8], frame_command[23:16],
	// frame_id[31:24], frame_length[39:32], received_check[55:40]
	output logic [slfr_pkg::OUT_TDATA_W-1:0] m_tdata,
	// kind[1:0]
	output logic [slfr_pkg::OUT_TUSER_W-1:0] m_tuser,
	output logic                             m_tlast,
	input  logic                             cfg_we,
	input  logic [slfr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [slfr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	import slfr_pkg::*;

	cfg_t cfg;
	res_t res;
	res_t out_res;
	logic res_valid;
	logic item_valid;

	assign item_valid = s_tvalid && s_tready;

	// configuration registers
	slfr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// frame parser
	slfr_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.cmd        (s_tuser[0]),
		.rx_byte    (s_tdata[7:0]),
		.cfg        (cfg),
		.res_valid  (res_valid),
		.res        (res)
	);

	// output register and skid slot
	slfr_out_skid u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (res_valid),
		.in_res    (res),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_res   (out_res),
		.out_ready (m_tready)
	);

	// output packing
	assign m_tdata = {out_res.received_check, out_res.frame_length, out_res.frame_id,
		out_res.frame_command, out_res.payload_index, out_res.payload_byte};
	assign m_tuser = out_res.kind;
	assign m_tlast = out_res.last;

	// a full skid slot means the output register is full too
	`SLFR_ASSERT_IMPL(a_skid_implies_main, !s_tready, m_tvalid)
	// with both slots full and no take, the input side stays stalled
	`SLFR_ASSERT_NEXT(a_stall_holds, !s_tready && !m_tready, !s_tready && m_tvalid)
	// payload items carry no check word
	`SLFR_ASSERT_IMPL(a_payload_no_check, m_tvalid && m_tuser == KIND_PAYLOAD,
		m_tdata[55:40] == 16'd0)
	// only payload items can close a frame's data
	`SLFR_ASSERT_IMPL(a_last_only_payload, m_tvalid && m_tlast, m_tuser == KIND_PAYLOAD)

endmodule
